/* rtl/ntc_pkg.sv */
// package: shared types and constants of the thermistor linearizer
package ntc_pkg;

  localparam int RES_W = 26;
  localparam int TEMP_W = 16;
  localparam int STATUS_W = 2;
  localparam int LOG_W = 21;
  localparam int DIFF_W = 22;

  localparam logic [1:0] REG_DIVIDER = 2'd0;
  localparam logic [1:0] REG_BETA = 2'd1;
  localparam logic [1:0] REG_NOMINAL = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ZERO = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_SAT = 2'd2;

  localparam logic [15:0] DIVIDER_RESET = 16'd4400;
  localparam logic [13:0] BETA_RESET = 14'd4000;
  localparam logic [19:0] NOMINAL_RESET = 20'd4700;

  localparam logic [31:0] RES_MAX = 32'd67108863;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam logic [63:0] INV_T25_Q48 = ((64'd100 << 48) + 64'd14907) / 64'd29815;
  localparam logic [63:0] CENTI_Q48 = 64'd100 << 48;
  localparam logic signed [18:0] KELVIN_OFFSET = 19'sd27315;
  localparam logic signed [18:0] TEMP_HI = 19'sd30000;
  localparam logic signed [18:0] TEMP_LO = -19'sd5500;

  typedef struct packed {
    logic code_zero;
    logic r_zero;
    logic hot;
    logic neg;
    logic [RES_W-1:0] res_ohms;
  } ntc_side_t;

endpackage

/* rtl/ntc_if.sv */
// channel interfaces: adc code input and result output
interface ntc_code_if #(parameter int ADC_BITS = 10);
  logic valid;
  logic ready;
  logic [ADC_BITS-1:0] adc_code;
  modport source(output valid, output adc_code, input ready);
  modport sink(input valid, input adc_code, output ready);
endinterface

interface ntc_result_if;
  logic valid;
  logic ready;
  logic [25:0] resistance_ohms;
  logic signed [15:0] temp_centi_c;
  logic [1:0] status;
  modport source(output valid, output resistance_ohms, output temp_centi_c, output status,
                 input ready);
  modport sink(input valid, input resistance_ohms, input temp_centi_c, input status,
               output ready);
endinterface

/* rtl/ntc_thermistor_linearizer.sv */
// top level: ntc thermistor linearizer, beta equation in fixed point
// in_ch carries one adc code per beat from the divider midpoint; out_ch returns one
// result beat per code: thermistor resistance in ohms, temperature in 0.01 C and status
// (ok, zero code, saturated). the three registers sit on the apb port at 0x0, 0x4, 0x8:
// divider resistor, beta, nominal resistance at 25 C; write them only while idle.
// the datapath is a fixed pipeline of 112 + ADC_BITS stages (122 for 10 bits): a
// multiply stage, a resistance divider with one quotient bit per stage, a two-lane
// log2 unit with one mantissa squaring per stage, the ln/beta divider (53 stages),
// the kelvin reciprocal divider (17 stages) and an output register.
// throughput is one code per cycle. when out_ch stalls the whole pipeline holds and
// in_ch.ready falls, so nothing is dropped or repeated. reset clears every valid bit
// and loads the default register values; no clearing pass is needed.
module ntc_thermistor_linearizer
  import ntc_pkg::*;
#(
  parameter int ADC_BITS = 10
) (
  input  logic        clk,
  input  logic        rst,
  ntc_code_if.sink    in_ch,
  ntc_result_if.source out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int PROD_W = 16 + ADC_BITS;
  localparam int DEN1_W = ADC_BITS + 1;
  localparam int SIDE_W = $bits(ntc_side_t);
  localparam int MAG_W = DIFF_W - 1;
  localparam int LNP_W = MAG_W + 32;
  localparam int INV_W = LNP_W + 2;
  localparam int U_W = LNP_W + 1;
  localparam int NUM2_W = U_W + 2;
  localparam int TQ_W = 17;

  logic [15:0] divider_resistance;
  logic [13:0] beta_kelvin;
  logic [19:0] nominal_resistance;
  logic        en;
  logic        wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      divider_resistance <= DIVIDER_RESET;
      beta_kelvin <= BETA_RESET;
      nominal_resistance <= NOMINAL_RESET;
    end else if (wr) begin
      case (paddr[3:2])
        REG_DIVIDER: divider_resistance <= pwdata[15:0];
        REG_BETA:    beta_kelvin <= pwdata[13:0];
        REG_NOMINAL: nominal_resistance <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_DIVIDER: prdata = 32'(divider_resistance);
      REG_BETA:    prdata = 32'(beta_kelvin);
      REG_NOMINAL: prdata = 32'(nominal_resistance);
      default:     prdata = '0;
    endcase
  end

  logic [13:0] beta_eff;
  logic [19:0] nominal_eff;
  assign beta_eff = (beta_kelvin == '0) ? 14'd1 : beta_kelvin;
  assign nominal_eff = (nominal_resistance == '0) ? 20'd1 : nominal_resistance;

  // stage 0: product and divisor
  logic              v0;
  logic [PROD_W-1:0] prod0;
  logic [DEN1_W-1:0] den0;
  ntc_side_t         side0;

  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod0 <= PROD_W'(divider_resistance) * PROD_W'(in_ch.adc_code);
      den0 <= {1'b1, {ADC_BITS{1'b0}}} - {1'b0, in_ch.adc_code};
      side0 <= '{code_zero: (in_ch.adc_code == '0), r_zero: 1'b0, hot: 1'b0, neg: 1'b0,
                 res_ohms: '0};
    end
  end

  logic              vr;
  logic [PROD_W-1:0] r;
  ntc_side_t         side_r;

  ntc_div_pipe #(.NUM_W(PROD_W), .DEN_W(DEN1_W), .Q_W(PROD_W), .SIDE_W(SIDE_W)) u_div_res (
    .clk(clk), .rst(rst), .en(en), .in_valid(v0), .num(prod0), .den(den0), .side(side0),
    .out_valid(vr), .quo(r), .side_out(side_r)
  );

  // stage 1: resistance saturation and zero check
  logic        v1;
  logic [31:0] r1;
  ntc_side_t   side1;
  ntc_side_t   side1_next;
  logic [31:0] r_wide;
  assign r_wide = 32'(r);

  always_comb begin
    side1_next = side_r;
    side1_next.r_zero = (r_wide == '0);
    side1_next.res_ohms = (r_wide > RES_MAX) ? RES_MAX[RES_W-1:0] : r_wide[RES_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= vr;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1 <= r_wide;
      side1 <= side1_next;
    end
  end

  logic                     vl;
  logic signed [DIFF_W-1:0] ldiff;
  ntc_side_t                side_l;

  ntc_log2_diff #(.SIDE_W(SIDE_W)) u_log2 (
    .clk(clk), .rst(rst), .en(en), .in_valid(v1), .xa(r1), .xb(32'(nominal_eff)),
    .side(side1), .out_valid(vl), .diff(ldiff), .side_out(side_l)
  );

  // stage 2: scale by ln2
  logic             v2;
  logic [LNP_W-1:0] lnp2;
  ntc_side_t        side2;
  ntc_side_t        side2_next;
  logic [MAG_W-1:0] lmag;
  assign lmag = ldiff[DIFF_W-1] ? MAG_W'(-ldiff) : MAG_W'(ldiff);

  always_comb begin
    side2_next = side_l;
    side2_next.neg = ldiff[DIFF_W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= vl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lnp2 <= LNP_W'(lmag) * LNP_W'(LN2_Q32);
      side2 <= side2_next;
    end
  end

  logic             vt;
  logic [LNP_W-1:0] term;
  ntc_side_t        side_term;

  ntc_div_pipe #(.NUM_W(LNP_W), .DEN_W(14), .Q_W(LNP_W), .SIDE_W(SIDE_W)) u_div_beta (
    .clk(clk), .rst(rst), .en(en), .in_valid(v2), .num(lnp2), .den(beta_eff), .side(side2),
    .out_valid(vt), .quo(term), .side_out(side_term)
  );

  // stage 3: reciprocal temperature
  logic                    v3;
  logic [U_W-1:0]          u3;
  ntc_side_t               side3;
  ntc_side_t               side3_next;
  logic signed [INV_W-1:0] inv;
  assign inv = side_term.neg ? $signed(INV_W'(INV_T25_Q48)) - $signed(INV_W'(term))
                             : $signed(INV_W'(INV_T25_Q48)) + $signed(INV_W'(term));

  always_comb begin
    side3_next = side_term;
    side3_next.hot = (inv[INV_W-1] || inv == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= vt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u3 <= inv[U_W-1:0];
      side3 <= side3_next;
    end
  end

  // stage 4: rounded dividend
  logic              v4;
  logic [U_W-1:0]    u4;
  logic [NUM2_W-1:0] num4;
  ntc_side_t         side4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u4 <= u3;
      num4 <= NUM2_W'(CENTI_Q48) + NUM2_W'(u3 >> 1);
      side4 <= side3;
    end
  end

  // stage 5: quotient range check
  logic              v5;
  logic [U_W-1:0]    u5;
  logic [NUM2_W-1:0] num5;
  ntc_side_t         side5;
  ntc_side_t         side5_next;

  always_comb begin
    side5_next = side4;
    side5_next.hot = side4.hot
                  || ((U_W + TQ_W)'(num4) >= ((U_W + TQ_W)'(u4) << TQ_W));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u5 <= u4;
      num5 <= num4;
      side5 <= side5_next;
    end
  end

  logic            vk;
  logic [TQ_W-1:0] tk;
  ntc_side_t       side_k;

  ntc_div_pipe #(.NUM_W(NUM2_W), .DEN_W(U_W), .Q_W(TQ_W), .SIDE_W(SIDE_W)) u_div_kelvin (
    .clk(clk), .rst(rst), .en(en), .in_valid(v5), .num(num5), .den(u5), .side(side5),
    .out_valid(vk), .quo(tk), .side_out(side_k)
  );

  // output register
  logic                     v_out;
  logic [RES_W-1:0]         res_out;
  logic signed [TEMP_W-1:0] temp_out;
  logic [STATUS_W-1:0]      status_out;
  logic signed [18:0]       tc;
  logic signed [TEMP_W-1:0] temp_next;
  logic [STATUS_W-1:0]      status_next;

  assign en = !v_out || out_ch.ready;
  assign tc = $signed({2'b00, tk}) - KELVIN_OFFSET;

  always_comb begin
    if (side_k.code_zero) begin
      temp_next = '0;
      status_next = STATUS_ZERO;
    end else if (side_k.r_zero || side_k.hot || tc > TEMP_HI) begin
      temp_next = TEMP_W'(TEMP_HI);
      status_next = STATUS_SAT;
    end else if (tc < TEMP_LO) begin
      temp_next = TEMP_W'(TEMP_LO);
      status_next = STATUS_SAT;
    end else begin
      temp_next = TEMP_W'(tc);
      status_next = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= vk;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_out <= side_k.res_ohms;
      temp_out <= temp_next;
      status_out <= status_next;
    end
  end

  assign out_ch.valid = v_out;
  assign out_ch.resistance_ohms = res_out;
  assign out_ch.temp_centi_c = temp_out;
  assign out_ch.status = status_out;
endmodule

/* rtl/ntc_div_pipe.sv */
// pipelined restoring divider, one quotient bit per stage
module ntc_div_pipe #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 11,
  parameter int Q_W = 32,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side,
  output logic              out_valid,
  output logic [Q_W-1:0]    quo,
  output logic [SIDE_W-1:0] side_out
);
  localparam int CW = DEN_W + Q_W;

  logic              valid_q [Q_W+1];
  logic [Q_W-1:0]    quo_q [Q_W+1];
  logic [SIDE_W-1:0] side_q [Q_W+1];
  logic [CW-1:0]     rem_q [Q_W];
  logic [DEN_W-1:0]  den_q [Q_W];

  assign valid_q[0] = in_valid;
  assign quo_q[0] = '0;
  assign side_q[0] = side;
  assign rem_q[0] = CW'(num);
  assign den_q[0] = den;

  for (genvar i = 0; i < Q_W; i++) begin : g_stage
    localparam int J = Q_W - 1 - i;
    logic [CW-1:0] dsh;
    logic ge;
    assign dsh = CW'(den_q[i]) << J;
    assign ge = rem_q[i] >= dsh;

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[i+1] <= 1'b0;
      end else if (en) begin
        valid_q[i+1] <= valid_q[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        quo_q[i+1] <= quo_q[i] | (Q_W'(ge) << J);
        side_q[i+1] <= side_q[i];
      end
    end

    if (i < Q_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[i+1] <= ge ? rem_q[i] - dsh : rem_q[i];
          den_q[i+1] <= den_q[i];
        end
      end
    end
  end

  assign out_valid = valid_q[Q_W];
  assign quo = quo_q[Q_W];
  assign side_out = side_q[Q_W];
endmodule

/* rtl/ntc_log2_diff.sv */
// two-lane pipelined log2 in q16 by mantissa squaring, gives the signed difference
module ntc_log2_diff
  import ntc_pkg::*;
#(
  parameter int SIDE_W = 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [31:0]              xa,
  input  logic [31:0]              xb,
  input  logic [SIDE_W-1:0]        side,
  output logic                     out_valid,
  output logic signed [DIFF_W-1:0] diff,
  output logic [SIDE_W-1:0]        side_out
);
  localparam int NSQ = 16;

  function automatic logic [4:0] msb_pos(input logic [31:0] x);
    logic [4:0] p;
    p = '0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) p = 5'(i);
    end
    return p;
  endfunction

  logic              v1;
  logic [31:0]       x1 [2];
  logic [4:0]        n1 [2];
  logic [SIDE_W-1:0] side1;

  logic              v_q [NSQ+1];
  logic [31:0]       m_q [NSQ+1][2];
  logic [4:0]        n_q [NSQ+1][2];
  logic [15:0]       frac_q [NSQ+1][2];
  logic [SIDE_W-1:0] side_q [NSQ+1];

  logic              vd;
  logic signed [DIFF_W-1:0] d;
  logic [SIDE_W-1:0] side_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v_q[0] <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v_q[0] <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1[0] <= xa;
      x1[1] <= xb;
      n1[0] <= msb_pos(xa);
      n1[1] <= msb_pos(xb);
      side1 <= side;
      for (int l = 0; l < 2; l++) begin
        m_q[0][l] <= x1[l] << (5'd31 - n1[l]);
        n_q[0][l] <= n1[l];
        frac_q[0][l] <= '0;
      end
      side_q[0] <= side1;
    end
  end

  for (genvar k = 0; k < NSQ; k++) begin : g_sq
    logic [63:0] p [2];
    logic [32:0] s [2];
    always_comb begin
      for (int l = 0; l < 2; l++) begin
        p[l] = 64'(m_q[k][l]) * 64'(m_q[k][l]);
        s[l] = p[l][63:31];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k+1] <= 1'b0;
      end else if (en) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 2; l++) begin
          m_q[k+1][l] <= s[l][32] ? s[l][32:1] : s[l][31:0];
          frac_q[k+1][l] <= {frac_q[k][l][14:0], s[l][32]};
          n_q[k+1][l] <= n_q[k][l];
        end
        side_q[k+1] <= side_q[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else if (en) begin
      vd <= v_q[NSQ];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d <= $signed({1'b0, n_q[NSQ][0], frac_q[NSQ][0]})
         - $signed({1'b0, n_q[NSQ][1], frac_q[NSQ][1]});
      side_d <= side_q[NSQ];
    end
  end

  assign out_valid = vd;
  assign diff = d;
  assign side_out = side_d;
endmodule
